FILE: rtl/core/lfb_pkg.sv
// Shared constants for the LED frame buffer with decay.
// Used by led_frame_buffer_with_decay_unit; no dependencies.
package lfb_pkg;

    localparam int MAX_LEDS = 64;
    localparam int IDX_W    = $clog2(MAX_LEDS);
    localparam int CNT_W    = 7;
    localparam int PCT_W    = 7;
    localparam int WORD_W   = 24;

    // floor(x / 100) as (x * 5243) >> 19, exact for x below 43690
    localparam int PCT_RECIP = 5243;
    localparam int PCT_SHIFT = 19;
    localparam int PROD_W    = 8 + PCT_W;
    localparam int RECIP_W   = 13;
    localparam int QUOT_W    = PROD_W + RECIP_W - PCT_SHIFT;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_NONE  = 2'd3;

    localparam logic REQ_SET  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [1:0] CFG_LED_COUNT     = 2'd0;
    localparam logic [1:0] CFG_DECAY_PERCENT = 2'd1;

    localparam logic [CNT_W-1:0] LED_COUNT_RESET = 7'd64;
    localparam logic [PCT_W-1:0] DECAY_RESET     = 7'd90;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

endpackage

FILE: rtl/core/led_frame_buffer_with_decay_unit.sv
// LED frame buffer with decay: one synchronous RGB store with read-modify-write.
// Depends on lfb_pkg.
//
// Set item: accepted every cycle while not busy, no result; merged and written in the next cycle.
// Tick item with n LEDs in use: entries are read in order and the results registered,
// then one per cycle; busy stays high until the final write-back goes out.
// The pace of a tick is the single read port of the frame store.
// Reset: store reads as zero through per-entry valid flops, no clearing pass.
module led_frame_buffer_with_decay_unit
    import lfb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [6:0]       cfg_wdata,
    input  logic             start,
    output logic             busy,
    input  logic             req_type,
    input  logic [5:0]       pixel_index,
    input  logic [1:0]       channel,
    input  logic [7:0]       value,
    output logic             result_valid,
    output logic [5:0]       out_index,
    output logic [7:0]       red,
    output logic [7:0]       green,
    output logic [7:0]       blue,
    output logic             last
);

    logic [CNT_W-1:0]  led_count_reg;
    logic [PCT_W-1:0]  decay_reg;
    logic [CNT_W-1:0]  n_use;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  rd_ptr_reg;

    logic [WORD_W-1:0] mem [MAX_LEDS];
    logic [MAX_LEDS-1:0] valid_reg;
    logic [WORD_W-1:0] rd_word_reg;
    logic              rd_valid_reg;
    logic [IDX_W-1:0]  rd_addr;

    logic              accept;
    logic              set_ok;

    // set pipeline
    logic              set_v_reg;
    logic [IDX_W-1:0]  set_idx_reg;
    logic [1:0]        set_ch_reg;
    logic [7:0]        set_val_reg;
    logic              fwd_reg;
    logic [WORD_W-1:0] fwd_word_reg;
    logic [WORD_W-1:0] set_base;
    logic [WORD_W-1:0] set_word;

    // tick pipeline
    logic              s1_v_reg;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic              s1_last_reg;
    logic [WORD_W-1:0] s1_word;
    logic              s2_v_reg;
    logic [IDX_W-1:0]  s2_idx_reg;
    logic [PROD_W-1:0] prod_reg [3];
    logic [WORD_W-1:0] decay_word;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;

    assign n_use  = (led_count_reg > CNT_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS) : led_count_reg;
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign set_ok = accept && (req_type == REQ_SET)
                    && ({1'b0, pixel_index} < n_use) && (channel != CH_NONE);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg <= LED_COUNT_RESET;
            decay_reg     <= DECAY_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LED_COUNT:     led_count_reg <= cfg_wdata;
                CFG_DECAY_PERCENT: decay_reg     <= cfg_wdata;
                default:           ;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req_type == REQ_TICK) && (n_use != '0))
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if ({1'b0, rd_ptr_reg} == n_use - CNT_W'(1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                // leave once the final write-back goes out
                if (!s1_v_reg && s2_v_reg)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_ptr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_RUN)
                rd_ptr_reg <= rd_ptr_reg + IDX_W'(1);
            else
                rd_ptr_reg <= '0;
        end
    end

    // frame store
    assign rd_addr = (state_reg == ST_RUN) ? rd_ptr_reg : pixel_index;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_word_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[rd_addr];
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
        end
    end

    // set read-modify-write; forward a merge still in flight to the same entry
    assign set_base = fwd_reg ? fwd_word_reg : (rd_valid_reg ? rd_word_reg : '0);

    always_comb
    begin
        set_word = set_base;
        case (set_ch_reg)
            CH_RED:   set_word[23:16] = set_val_reg;
            CH_GREEN: set_word[15:8]  = set_val_reg;
            CH_BLUE:  set_word[7:0]   = set_val_reg;
            default:  set_word = set_base;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_v_reg <= 1'b0;
            fwd_reg   <= 1'b0;
        end
        else
        begin
            set_v_reg <= set_ok;
            fwd_reg   <= set_ok && set_v_reg && (set_idx_reg == pixel_index);
        end
    end

    always_ff @(posedge clk)
    begin
        set_idx_reg  <= pixel_index;
        set_ch_reg   <= channel;
        set_val_reg  <= value;
        fwd_word_reg <= set_word;
    end

    // tick: read, show and multiply, then scale and write back
    assign s1_word = rd_valid_reg ? rd_word_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg     <= 1'b0;
            s2_v_reg     <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            s1_v_reg     <= (state_reg == ST_RUN);
            s2_v_reg     <= s1_v_reg;
            result_valid <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_idx_reg  <= rd_ptr_reg;
        s1_last_reg <= ({1'b0, rd_ptr_reg} == n_use - CNT_W'(1));
        s2_idx_reg  <= s1_idx_reg;
        out_index   <= s1_idx_reg;
        last        <= s1_last_reg;
        red         <= s1_word[23:16];
        green       <= s1_word[15:8];
        blue        <= s1_word[7:0];
        prod_reg[0] <= s1_word[23:16] * decay_reg;
        prod_reg[1] <= s1_word[15:8]  * decay_reg;
        prod_reg[2] <= s1_word[7:0]   * decay_reg;
    end

    always_comb
    begin
        logic [PROD_W+RECIP_W-1:0] full;
        logic [QUOT_W-1:0]         quot;
        decay_word = '0;
        for (int k = 0; k < 3; k++)
        begin
            full = prod_reg[k] * RECIP_W'(PCT_RECIP);
            quot = full[PROD_W+RECIP_W-1:PCT_SHIFT];
            // saturate when decay is above one hundred percent
            decay_word[WORD_W-1-8*k -: 8] = (quot > QUOT_W'(255)) ? 8'hFF : quot[7:0];
        end
    end

    // write port: set merges and tick write-backs never meet
    assign wr_en   = set_v_reg || s2_v_reg;
    assign wr_addr = s2_v_reg ? s2_idx_reg : set_idx_reg;
    assign wr_data = s2_v_reg ? decay_word : set_word;

    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(set_v_reg && s2_v_reg))
        else $error("set merge and tick write-back collide");

    a_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> busy)
        else $error("result shown while idle");

    a_run_contig: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> result_valid && (out_index == $past(out_index) + 6'd1))
        else $error("tick run broken or out of order");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last |=> !result_valid)
        else $error("result after last pixel");

endmodule
